>>> rtl/core/tsg_pkg.sv
package tsg_pkg;

  // Default field widths: signed Q16.16 coordinates and gradients.
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  typedef logic [1:0] vertex_t;

  localparam vertex_t VertexFirst = 2'd0;
  localparam vertex_t VertexLast  = 2'd3;

endpackage

>>> rtl/core/tet_shape_gradient_unit.sv
// Linear tetrahedron shape-function gradients.
// Input channel: one transaction carries the four vertices of a tetrahedron
// (v0..v3, x/y/z, signed fixed point with FRAC_BITS fraction bits), taken at
// an edge where in_valid_i is high and in_stall_o is low.
// Output channel: every tetrahedron gives four transactions, vertex 0 to 3 in
// order. Each carries the gradient of that vertex's shape function, rounded to
// nearest (ties away from zero) and saturated. last_o marks vertex 3.
// singular_o flags a zero edge-matrix determinant; the gradients are then zero.
// The output serializer sends the four vertex results one per cycle, unless
// a stall holds them, through the three restoring-divider lanes (one per
// gradient component); a new tetrahedron enters only when the serializer
// is empty or holds vertex 3.
// Stall: out_stall_i freezes the whole pipeline while out_valid_o is high;
// the output register holds its transaction, and in_stall_o rises while the
// pipeline is frozen or the serializer still has vertices left to send.
// Nothing is lost or repeated.
// Reset: asynchronous, clears all valid bits; no transaction is in flight after.
module tet_shape_gradient_unit #(
  parameter int unsigned COORD_BITS = tsg_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = tsg_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] v0_x_i,
  input  logic signed [COORD_BITS-1:0] v0_y_i,
  input  logic signed [COORD_BITS-1:0] v0_z_i,
  input  logic signed [COORD_BITS-1:0] v1_x_i,
  input  logic signed [COORD_BITS-1:0] v1_y_i,
  input  logic signed [COORD_BITS-1:0] v1_z_i,
  input  logic signed [COORD_BITS-1:0] v2_x_i,
  input  logic signed [COORD_BITS-1:0] v2_y_i,
  input  logic signed [COORD_BITS-1:0] v2_z_i,
  input  logic signed [COORD_BITS-1:0] v3_x_i,
  input  logic signed [COORD_BITS-1:0] v3_y_i,
  input  logic signed [COORD_BITS-1:0] v3_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tsg_pkg::vertex_t             vertex_o,
  output logic signed [COORD_BITS-1:0] grad_x_o,
  output logic signed [COORD_BITS-1:0] grad_y_o,
  output logic signed [COORD_BITS-1:0] grad_z_o,
  output logic                         singular_o,
  output logic                         last_o
);
  import tsg_pkg::*;

  // Exact widths of every intermediate value.
  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned EW  = C + 1;        // edge
  localparam int unsigned PW  = 2 * EW;       // edge product
  localparam int unsigned AW  = PW + 1;       // cofactor
  localparam int unsigned SW  = AW + 2;       // column sum of three cofactors
  localparam int unsigned DW  = 3 * C + 6;    // determinant
  localparam int unsigned LB  = C + 2;        // low slice of a cofactor
  localparam int unsigned HW  = AW - LB;      // high slice of a cofactor
  localparam int unsigned PHW = EW + HW;
  localparam int unsigned PLW = EW + LB + 1;
  localparam int unsigned QB  = C + 1;        // quotient bits below overflow
  localparam int unsigned NS  = QB + 1;       // divider steps, overflow bit included
  localparam int unsigned NA  = SW + 2 * FRAC_BITS;
  localparam int unsigned ND  = DW + QB;
  localparam int unsigned RW  = ((NA > ND) ? NA : ND) + 1;

  logic adv;
  logic front_adv;

  // ---------------------------------------------------------------------------
  // Vertex inputs as an array: vin[vertex][axis]
  // ---------------------------------------------------------------------------
  logic signed [C-1:0] vin [4][3];

  assign vin[0][0] = v0_x_i;
  assign vin[0][1] = v0_y_i;
  assign vin[0][2] = v0_z_i;
  assign vin[1][0] = v1_x_i;
  assign vin[1][1] = v1_y_i;
  assign vin[1][2] = v1_z_i;
  assign vin[2][0] = v2_x_i;
  assign vin[2][1] = v2_y_i;
  assign vin[2][2] = v2_z_i;
  assign vin[3][0] = v3_x_i;
  assign vin[3][1] = v3_y_i;
  assign vin[3][2] = v3_z_i;

  // ---------------------------------------------------------------------------
  // Front pipeline: edges, products, cofactors, determinant in six stages.
  // It moves only when the serializer can take its last stage.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic signed [EW-1:0]  e1_q   [3][3];   // [row][col]
  logic signed [PW-1:0]  p1_q   [3][3];   // first cofactor product, [row][col]
  logic signed [PW-1:0]  p2_q   [3][3];   // second cofactor product
  logic signed [EW-1:0]  e2_q   [3];      // row 0 of the edge matrix
  logic signed [EW-1:0]  e3_q   [3];
  logic signed [AW-1:0]  adj3_q [3][3];   // adj[col][row]
  logic signed [AW-1:0]  adj4_q [3][3];
  logic signed [AW-1:0]  adj5_q [3][3];
  logic signed [AW-1:0]  adj6_q [3][3];
  logic signed [PHW-1:0] ph4_q  [3];
  logic signed [PLW-1:0] pl4_q  [3];
  logic signed [SW-1:0]  cs4_q  [3];
  logic signed [SW-1:0]  cs5_q  [3];
  logic signed [SW-1:0]  cs6_q  [3];
  logic signed [DW-1:0]  dt5_q  [3];
  logic signed [DW-1:0]  det6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (front_adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          // Edge matrix: columns are edges from vertex 0.
          e1_q[r][c] <= EW'(vin[c+1][r]) - EW'(vin[0][r]);
          // Cyclic indexing carries the cofactor sign.
          p1_q[r][c] <= e1_q[(r+1)%3][(c+1)%3] * e1_q[(r+2)%3][(c+2)%3];
          p2_q[r][c] <= e1_q[(r+1)%3][(c+2)%3] * e1_q[(r+2)%3][(c+1)%3];
          adj3_q[c][r] <= AW'(p1_q[r][c]) - AW'(p2_q[r][c]);
          adj4_q[c][r] <= adj3_q[c][r];
          adj5_q[c][r] <= adj4_q[c][r];
          adj6_q[c][r] <= adj5_q[c][r];
        end
      end
      for (int c = 0; c < 3; c++) begin
        e2_q[c] <= e1_q[0][c];
        e3_q[c] <= e2_q[c];
        // Split the wide cofactor so each multiplier stays near 33x35.
        ph4_q[c] <= e3_q[c] * $signed(adj3_q[c][0][AW-1:LB]);
        pl4_q[c] <= e3_q[c] * $signed({1'b0, adj3_q[c][0][LB-1:0]});
        dt5_q[c] <= (DW'(ph4_q[c]) <<< LB) + DW'(pl4_q[c]);
      end
      for (int j = 0; j < 3; j++) begin
        cs4_q[j] <= SW'(adj3_q[0][j]) + SW'(adj3_q[1][j]) + SW'(adj3_q[2][j]);
        cs5_q[j] <= cs4_q[j];
        cs6_q[j] <= cs5_q[j];
      end
      det6_q <= dt5_q[0] + dt5_q[1] + dt5_q[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Serializer: hold one tetrahedron and send one vertex per cycle unless the output stalls.
  // ---------------------------------------------------------------------------
  logic                 v7_q;
  vertex_t              cnt7_q;
  logic signed [AW-1:0] adj7_q [3][3];
  logic signed [SW-1:0] cs7_q  [3];
  logic signed [DW-1:0] det7_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign front_adv  = adv && (!v7_q || (cnt7_q == VertexLast));
  assign in_stall_o = !front_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q   <= 1'b0;
      cnt7_q <= VertexFirst;
    end else if (front_adv) begin
      v7_q   <= v6_q;
      cnt7_q <= VertexFirst;
    end else if (adv) begin
      cnt7_q <= cnt7_q + vertex_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      adj7_q <= adj6_q;
      cs7_q  <= cs6_q;
      det7_q <= det6_q;
    end
  end

  // Select the numerator for this vertex and take magnitudes.
  logic [RW-1:0] num_mag [3];
  logic          num_neg [3];
  logic [DW-1:0] det_mag;

  always_comb begin
    vertex_t              row;
    logic signed [SW-1:0] n;
    row     = cnt7_q - vertex_t'(1);
    det_mag = det7_q[DW-1] ? DW'(-det7_q) : DW'(det7_q);
    for (int j = 0; j < 3; j++) begin
      if (cnt7_q == VertexFirst) begin
        n = -cs7_q[j];
      end else begin
        n = SW'(adj7_q[row[1:0]][j]);
      end
      num_neg[j] = n[SW-1] ^ det7_q[DW-1];
      num_mag[j] = RW'(n[SW-1] ? SW'(-n) : SW'(n)) << (2 * FRAC_BITS);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: three restoring lanes, one quotient bit per stage, MSB first.
  // Stage 0 is the entry register; the top quotient bit flags overflow.
  // ---------------------------------------------------------------------------
  logic            dv_q   [NS+1];
  logic [RW-1:0]   dr_q   [NS+1][3];
  logic [QB:0]     dq_q   [NS+1][3];
  logic            dn_q   [NS+1][3];
  logic [DW-1:0]   dad_q  [NS+1];
  vertex_t         dvx_q  [NS+1];
  logic            dsg_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        dr_q[0][l] <= num_mag[l];
        dq_q[0][l] <= '0;
        dn_q[0][l] <= num_neg[l];
      end
      dad_q[0] <= det_mag;
      dvx_q[0] <= cnt7_q;
      dsg_q[0] <= (det7_q == '0);
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    localparam int unsigned Sh = NS - k;

    logic [RW-1:0] dsub;
    assign dsub = RW'(dad_q[k-1]) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (adv) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if (dr_q[k-1][l] >= dsub) begin
            dr_q[k][l] <= dr_q[k-1][l] - dsub;
            dq_q[k][l] <= dq_q[k-1][l] | ((QB+1)'(1) << Sh);
          end else begin
            dr_q[k][l] <= dr_q[k-1][l];
            dq_q[k][l] <= dq_q[k-1][l];
          end
          dn_q[k][l] <= dn_q[k-1][l];
        end
        dad_q[k] <= dad_q[k-1];
        dvx_q[k] <= dvx_q[k-1];
        dsg_q[k] <= dsg_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Round, saturate, apply sign; output register.
  // ---------------------------------------------------------------------------
  logic [C-1:0] grad_d [3];

  always_comb begin
    logic          rnd;
    logic [QB:0]   qr;
    logic [QB:0]   lim;
    logic [QB:0]   mag;
    logic [QB:0]   sgn;
    for (int l = 0; l < 3; l++) begin
      rnd = ({dr_q[NS][l], 1'b0} >= (RW+1)'(dad_q[NS]));
      qr  = (QB+1)'(dq_q[NS][l][QB-1:0]) + (QB+1)'(rnd);
      lim = ((QB+1)'(1) << (C - 1)) - (QB+1)'(!dn_q[NS][l]);
      mag = (dq_q[NS][l][QB] || (qr > lim)) ? lim : qr;
      sgn = dn_q[NS][l] ? -mag : mag;
      grad_d[l] = dsg_q[NS] ? '0 : sgn[C-1:0];
    end
  end

  logic         ov_q;
  vertex_t      ovx_q;
  logic [C-1:0] og_q [3];
  logic         osg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= dv_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ovx_q <= dvx_q[NS];
      og_q  <= grad_d;
      osg_q <= dsg_q[NS];
    end
  end

  assign out_valid_o = ov_q;
  assign vertex_o    = ovx_q;
  assign grad_x_o    = og_q[0];
  assign grad_y_o    = og_q[1];
  assign grad_z_o    = og_q[2];
  assign singular_o  = osg_q;
  assign last_o      = (ovx_q == VertexLast);

endmodule

>>> rtl/core/tsg_checker.sv
module tsg_checker #(
  parameter int unsigned COORD_BITS = tsg_pkg::CoordBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input tsg_pkg::vertex_t             vertex_o,
  input logic signed [COORD_BITS-1:0] grad_x_o,
  input logic signed [COORD_BITS-1:0] grad_y_o,
  input logic signed [COORD_BITS-1:0] grad_z_o,
  input logic                         singular_o,
  input logic                         last_o
);
  import tsg_pkg::*;

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_o) &&
      $stable(grad_x_o) && $stable(grad_y_o) && $stable(grad_z_o) &&
      $stable(singular_o) && $stable(last_o))
    else $error("stalled result changed");

  // The four vertices of one tetrahedron leave back to back and agree on singular.
  a_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o &&
      (vertex_o == vertex_t'($past(vertex_o) + vertex_t'(1))) &&
      (singular_o == $past(singular_o)))
    else $error("vertex sequence broken");

  // A singular tetrahedron gives zero gradients, and last marks vertex 3.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!singular_o || ((grad_x_o == '0) && (grad_y_o == '0) &&
      (grad_z_o == '0))) && (last_o == (vertex_o == VertexLast)))
    else $error("singular or last flag inconsistent");

endmodule

bind tet_shape_gradient_unit tsg_checker #(.COORD_BITS(COORD_BITS)) u_tsg_checker (.*);
